### hdl/aarm_pkg.sv
// Package for the axis-angle rotation matrix block: field widths, working
// number formats, the CORDIC arctangent table and the item and stage types.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package aarm_pkg;

   // Field widths.
   localparam int DATA_WIDTH  = 16;
   localparam int ANGLE_WIDTH = 16;
   localparam int FRAC_BITS   = DATA_WIDTH - 1;

   // Working formats: Q30 fixed point, 32-bit turn fraction for the phase.
   localparam int WORK_BITS    = 30;
   localparam int CORDIC_STEPS = 30;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int PHASE_W      = 32;
   localparam int XY_W         = 32;
   localparam int Z_W          = PHASE_W + 1;
   localparam int AQ_W         = 32;
   localparam int PR_W         = 2 * AQ_W;
   localparam int CC_W         = 34;
   localparam int PC_W         = AQ_W + CC_W;
   localparam int QW           = 34;
   localparam int SUM_W        = 36;

   // Shifts that bring an axis component to Q30.
   localparam int AXIS_UP = (FRAC_BITS <= WORK_BITS) ? WORK_BITS - FRAC_BITS : 0;
   localparam int AXIS_DN = (FRAC_BITS > WORK_BITS) ? FRAC_BITS - WORK_BITS : 0;

   // Shifts that bring a Q30 sum to the output format.
   localparam int RND_SH = AXIS_UP;
   localparam int UP_SH  = AXIS_DN;
   localparam int R_W    = SUM_W + UP_SH;

   localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
   localparam logic signed [CC_W-1:0] ONE_Q30     = CC_W'(1) << WORK_BITS;
   localparam logic signed [PR_W-1:0] HALF_PR     = PR_W'(1) << (WORK_BITS - 1);
   localparam logic signed [PC_W-1:0] HALF_PC     = PC_W'(1) << (WORK_BITS - 1);
   localparam logic signed [SUM_W-1:0] RND_HALF   =
      (RND_SH > 0) ? (SUM_W'(1) << (RND_SH - 1)) : SUM_W'(0);
   localparam logic signed [R_W-1:0] SAT_HI = (R_W'(1) << FRAC_BITS) - R_W'(1);
   localparam logic signed [R_W-1:0] SAT_LO = -(R_W'(1) << FRAC_BITS);

   // atan(2^-i) in units of 2^-32 turn.
   localparam logic [PHASE_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] axis_x;
      logic signed [DATA_WIDTH-1:0] axis_y;
      logic signed [DATA_WIDTH-1:0] axis_z;
      logic        [ANGLE_WIDTH-1:0] angle;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] m00;
      logic signed [DATA_WIDTH-1:0] m01;
      logic signed [DATA_WIDTH-1:0] m02;
      logic signed [DATA_WIDTH-1:0] m10;
      logic signed [DATA_WIDTH-1:0] m11;
      logic signed [DATA_WIDTH-1:0] m12;
      logic signed [DATA_WIDTH-1:0] m20;
      logic signed [DATA_WIDTH-1:0] m21;
      logic signed [DATA_WIDTH-1:0] m22;
   } rsp_type;

   // One CORDIC pipeline stage: rotation state plus the axis riding along.
   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   flip;
      logic signed [AQ_W-1:0] ax;
      logic signed [AQ_W-1:0] ay;
      logic signed [AQ_W-1:0] az;
   } cordic_type;

endpackage

`default_nettype wire

### hdl/aarm_cordic.sv
// Unrolled rotation-mode CORDIC, one micro-rotation per register stage.
// Depends on aarm_pkg for the stage type, widths and arctangent table.
`default_nettype none

module aarm_cordic (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire aarm_pkg::cordic_type in_data,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output aarm_pkg::cordic_type     out_data
);
   import aarm_pkg::*;

   function automatic cordic_type cordic_step(cordic_type s, logic [STEP_W-1:0] k);
      cordic_type r;
      logic signed [XY_W-1:0] dx;
      logic signed [XY_W-1:0] dy;
      r  = s;
      dx = s.y >>> k;
      dy = s.x >>> k;
      if (!s.z[Z_W-1]) begin
         r.x = s.x - dx;
         r.y = s.y + dy;
         r.z = s.z - Z_W'(ATAN_TURNS[k]);
      end else begin
         r.x = s.x + dx;
         r.y = s.y - dy;
         r.z = s.z + Z_W'(ATAN_TURNS[k]);
      end
      return r;
   endfunction

   cordic_type stage_ff  [CORDIC_STEPS];
   cordic_type stage_in  [CORDIC_STEPS];
   cordic_type prev      [CORDIC_STEPS];
   logic       vld_ff    [CORDIC_STEPS];
   logic       prev_vld  [CORDIC_STEPS];
   logic       can_load  [CORDIC_STEPS+1];

   assign can_load[CORDIC_STEPS] = out_ready;

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      if (k == 0) begin : g_first
         assign prev[k]     = in_data;
         assign prev_vld[k] = in_valid;
      end else begin : g_next
         assign prev[k]     = stage_ff[k-1];
         assign prev_vld[k] = vld_ff[k-1];
      end

      // A stage takes new data when it is empty or its successor moves.
      assign can_load[k] = !vld_ff[k] || can_load[k+1];
      assign stage_in[k] = cordic_step(prev[k], STEP_W'(k));

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (can_load[k]) begin
            vld_ff[k] <= prev_vld[k];
         end
      end

      always_ff @(posedge clock) begin
         if (can_load[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign in_ready  = can_load[0];
   assign out_valid = vld_ff[CORDIC_STEPS-1];
   assign out_data  = stage_ff[CORDIC_STEPS-1];

endmodule

`default_nettype wire

### hdl/axis_angle_rotation_matrix.sv
// Top level of the axis-angle to rotation matrix block (Rodrigues form).
// Depends on aarm_pkg and instantiates the CORDIC pipeline aarm_cordic.
`default_nettype none

// The block takes one item per cycle on the req_ channel: a unit rotation
// axis (three signed Q1.15 components) and a binary angle where 2^16 is one
// full turn. For each item it returns one item on the rsp_ channel holding
// the nine entries of R = c*I + (1-c)*a*a^T + s*[a]x as signed Q1.15, each
// rounded and saturated, so +1.0 comes out as the largest positive code.
//
// An item is accepted on a rising edge with req_valid high and req_stall
// low; a result is taken on an edge with rsp_valid high and rsp_stall low.
// Between acceptance and rsp_valid an item passes one register stage for
// each of the 30 CORDIC micro-rotations, then five stages for the multiplier
// tree and final rounding and saturation. With rsp_stall low, the sustained
// rate is one item per cycle, set by the unrolled CORDIC and product stages.
//
// When the receiver stalls, the output register holds its result and each
// stage behind it keeps filling until it meets a full stage, so bubbles are
// squeezed out before req_stall is raised. No item is lost or repeated.
// A synchronous reset empties every stage; payload registers are not reset.

module axis_angle_rotation_matrix (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire aarm_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output aarm_pkg::rsp_type     rsp_data
);
   import aarm_pkg::*;

   // Bring a signed Q1.FRAC_BITS component to Q30.
   function automatic logic signed [AQ_W-1:0] to_q30(logic signed [DATA_WIDTH-1:0] v);
      logic signed [AQ_W-1:0] w;
      w = AQ_W'(v);
      w = w <<< AXIS_UP;
      w = w >>> AXIS_DN;
      return w;
   endfunction

   // Product of two Q30 values brought back to Q30, rounding half up.
   function automatic logic signed [QW-1:0] rnd_prod(logic signed [PR_W-1:0] p);
      logic signed [PR_W-1:0] t;
      t = p + HALF_PR;
      t = t >>> WORK_BITS;
      return QW'(t);
   endfunction

   function automatic logic signed [QW-1:0] rnd_wide(logic signed [PC_W-1:0] p);
      logic signed [PC_W-1:0] t;
      t = p + HALF_PC;
      t = t >>> WORK_BITS;
      return QW'(t);
   endfunction

   // Q30 sum to the output format, rounded half up and saturated.
   function automatic logic signed [DATA_WIDTH-1:0] to_field(logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] t;
      logic signed [R_W-1:0]   r;
      t = v + RND_HALF;
      t = t >>> RND_SH;
      r = R_W'(t);
      r = r <<< UP_SH;
      if (r > SAT_HI) begin
         r = SAT_HI;
      end else if (r < SAT_LO) begin
         r = SAT_LO;
      end
      return DATA_WIDTH'(r);
   endfunction

   // ------------------------------------------------------------------
   // Entry: place the angle in a 32-bit turn fraction. Angles in the left
   // half plane are turned by half a turn, and c and s negated later.
   // ------------------------------------------------------------------
   logic [PHASE_W-1:0] phase;
   logic [PHASE_W-1:0] phase_fold;
   logic               flip;
   cordic_type         cordic_in;
   logic               cordic_in_ready;
   logic               cordic_out_valid;
   cordic_type         cordic_out;

   always_comb begin
      phase      = PHASE_W'(req_data.angle) << (PHASE_W - ANGLE_WIDTH);
      flip       = phase[PHASE_W-1] ^ phase[PHASE_W-2];
      phase_fold = phase;
      if (flip) begin
         phase_fold[PHASE_W-1] = ~phase[PHASE_W-1];
      end
      cordic_in.x    = CORDIC_GAIN;
      cordic_in.y    = '0;
      cordic_in.z    = Z_W'($signed(phase_fold));
      cordic_in.flip = flip;
      cordic_in.ax   = to_q30(req_data.axis_x);
      cordic_in.ay   = to_q30(req_data.axis_y);
      cordic_in.az   = to_q30(req_data.axis_z);
   end

   // Per-stage load enables; a stage moves when empty or its successor moves.
   logic ld_a;
   logic ld_b;
   logic ld_c;
   logic ld_d;
   logic ld_e;

   aarm_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (cordic_in_ready),
      .in_data   (cordic_in),
      .out_valid (cordic_out_valid),
      .out_ready (ld_a),
      .out_data  (cordic_out)
   );

   assign req_stall = !cordic_in_ready;

   // ------------------------------------------------------------------
   // Stage A: fix the signs of c and s, form 1-c, and the raw axis products.
   // ------------------------------------------------------------------
   logic                   va_ff;
   logic signed [XY_W-1:0] c_a_ff, c_a_in;
   logic signed [XY_W-1:0] s_a_ff, s_a_in;
   logic signed [CC_W-1:0] cc_a_ff;
   logic signed [AQ_W-1:0] ax_a_ff, ay_a_ff, az_a_ff;
   logic signed [PR_W-1:0] pxx_a_ff, pyy_a_ff, pzz_a_ff;
   logic signed [PR_W-1:0] pxy_a_ff, pxz_a_ff, pyz_a_ff;

   always_comb begin
      c_a_in = cordic_out.flip ? -cordic_out.x : cordic_out.x;
      s_a_in = cordic_out.flip ? -cordic_out.y : cordic_out.y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (ld_a) begin
         va_ff <= cordic_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_a) begin
         c_a_ff   <= c_a_in;
         s_a_ff   <= s_a_in;
         cc_a_ff  <= ONE_Q30 - CC_W'(c_a_in);
         ax_a_ff  <= cordic_out.ax;
         ay_a_ff  <= cordic_out.ay;
         az_a_ff  <= cordic_out.az;
         pxx_a_ff <= PR_W'(cordic_out.ax) * PR_W'(cordic_out.ax);
         pyy_a_ff <= PR_W'(cordic_out.ay) * PR_W'(cordic_out.ay);
         pzz_a_ff <= PR_W'(cordic_out.az) * PR_W'(cordic_out.az);
         pxy_a_ff <= PR_W'(cordic_out.ax) * PR_W'(cordic_out.ay);
         pxz_a_ff <= PR_W'(cordic_out.ax) * PR_W'(cordic_out.az);
         pyz_a_ff <= PR_W'(cordic_out.ay) * PR_W'(cordic_out.az);
      end
   end

   // ------------------------------------------------------------------
   // Stage B: axis products rounded to Q30; raw axis times sine products.
   // ------------------------------------------------------------------
   logic                   vb_ff;
   logic signed [XY_W-1:0] c_b_ff;
   logic signed [CC_W-1:0] cc_b_ff;
   logic signed [AQ_W-1:0] qxx_b_ff, qyy_b_ff, qzz_b_ff;
   logic signed [AQ_W-1:0] qxy_b_ff, qxz_b_ff, qyz_b_ff;
   logic signed [PR_W-1:0] pxs_b_ff, pys_b_ff, pzs_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (ld_b) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_b) begin
         c_b_ff   <= c_a_ff;
         cc_b_ff  <= cc_a_ff;
         qxx_b_ff <= AQ_W'(rnd_prod(pxx_a_ff));
         qyy_b_ff <= AQ_W'(rnd_prod(pyy_a_ff));
         qzz_b_ff <= AQ_W'(rnd_prod(pzz_a_ff));
         qxy_b_ff <= AQ_W'(rnd_prod(pxy_a_ff));
         qxz_b_ff <= AQ_W'(rnd_prod(pxz_a_ff));
         qyz_b_ff <= AQ_W'(rnd_prod(pyz_a_ff));
         pxs_b_ff <= PR_W'(ax_a_ff) * PR_W'(s_a_ff);
         pys_b_ff <= PR_W'(ay_a_ff) * PR_W'(s_a_ff);
         pzs_b_ff <= PR_W'(az_a_ff) * PR_W'(s_a_ff);
      end
   end

   // ------------------------------------------------------------------
   // Stage C: axis products times 1-c; sine products rounded.
   // ------------------------------------------------------------------
   logic                   vc_ff;
   logic signed [XY_W-1:0] c_c_ff;
   logic signed [PC_W-1:0] pxxc_c_ff, pyyc_c_ff, pzzc_c_ff;
   logic signed [PC_W-1:0] pxyc_c_ff, pxzc_c_ff, pyzc_c_ff;
   logic signed [QW-1:0]   xs_c_ff, ys_c_ff, zs_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (ld_c) begin
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_c) begin
         c_c_ff    <= c_b_ff;
         pxxc_c_ff <= PC_W'(qxx_b_ff) * PC_W'(cc_b_ff);
         pyyc_c_ff <= PC_W'(qyy_b_ff) * PC_W'(cc_b_ff);
         pzzc_c_ff <= PC_W'(qzz_b_ff) * PC_W'(cc_b_ff);
         pxyc_c_ff <= PC_W'(qxy_b_ff) * PC_W'(cc_b_ff);
         pxzc_c_ff <= PC_W'(qxz_b_ff) * PC_W'(cc_b_ff);
         pyzc_c_ff <= PC_W'(qyz_b_ff) * PC_W'(cc_b_ff);
         xs_c_ff   <= rnd_prod(pxs_b_ff);
         ys_c_ff   <= rnd_prod(pys_b_ff);
         zs_c_ff   <= rnd_prod(pzs_b_ff);
      end
   end

   // ------------------------------------------------------------------
   // Stage D: round the 1-c products and form the nine exact Q30 sums.
   // ------------------------------------------------------------------
   logic                    vd_ff;
   logic signed [SUM_W-1:0] sum_d_ff [9];
   logic signed [SUM_W-1:0] sum_d_in [9];
   logic signed [QW-1:0]    xxc, yyc, zzc, xyc, xzc, yzc;
   logic signed [SUM_W-1:0] cw;

   always_comb begin
      xxc = rnd_wide(pxxc_c_ff);
      yyc = rnd_wide(pyyc_c_ff);
      zzc = rnd_wide(pzzc_c_ff);
      xyc = rnd_wide(pxyc_c_ff);
      xzc = rnd_wide(pxzc_c_ff);
      yzc = rnd_wide(pyzc_c_ff);
      cw  = SUM_W'(c_c_ff);
      sum_d_in[0] = SUM_W'(xxc) + cw;
      sum_d_in[1] = SUM_W'(xyc) - SUM_W'(zs_c_ff);
      sum_d_in[2] = SUM_W'(xzc) + SUM_W'(ys_c_ff);
      sum_d_in[3] = SUM_W'(xyc) + SUM_W'(zs_c_ff);
      sum_d_in[4] = SUM_W'(yyc) + cw;
      sum_d_in[5] = SUM_W'(yzc) - SUM_W'(xs_c_ff);
      sum_d_in[6] = SUM_W'(xzc) - SUM_W'(ys_c_ff);
      sum_d_in[7] = SUM_W'(yzc) + SUM_W'(xs_c_ff);
      sum_d_in[8] = SUM_W'(zzc) + cw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else if (ld_d) begin
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_d) begin
         sum_d_ff <= sum_d_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage E: output register, rounded and saturated to the field format.
   // ------------------------------------------------------------------
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   always_comb begin
      rsp_data_in.m00 = to_field(sum_d_ff[0]);
      rsp_data_in.m01 = to_field(sum_d_ff[1]);
      rsp_data_in.m02 = to_field(sum_d_ff[2]);
      rsp_data_in.m10 = to_field(sum_d_ff[3]);
      rsp_data_in.m11 = to_field(sum_d_ff[4]);
      rsp_data_in.m12 = to_field(sum_d_ff[5]);
      rsp_data_in.m20 = to_field(sum_d_ff[6]);
      rsp_data_in.m21 = to_field(sum_d_ff[7]);
      rsp_data_in.m22 = to_field(sum_d_ff[8]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ld_e) begin
         rsp_valid_ff <= vd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_e) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // The enable chain runs back from the output so empty stages keep filling.
   assign ld_e = !rsp_valid_ff || !rsp_stall;
   assign ld_d = !vd_ff || ld_e;
   assign ld_c = !vc_ff || ld_d;
   assign ld_b = !vb_ff || ld_c;
   assign ld_a = !va_ff || ld_b;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### test/axis_angle_rotation_matrix_test.sv
// Self-checking testbench for the axis-angle to rotation matrix block. Uses aarm_pkg.
// Drives a directed table of axis-angle items and then random items, and checks
// each matrix against a typed-in one or a bit-exact CORDIC and Rodrigues model.
`timescale 1ns / 1ps

module axis_angle_rotation_matrix_test;

   import aarm_pkg::req_type;
   import aarm_pkg::rsp_type;

   // Fixed-point layout of the block as built here: Q1.15 fields, Q30 inside.
   localparam int     FIELD_W      = 16;
   localparam int     Q30_UP       = 30 - (FIELD_W - 1);
   localparam longint ONE_Q30      = 64'sd1 <<< 30;
   localparam longint HALF_Q30     = 64'sd1 <<< 29;
   localparam longint HALF_LSB     = 64'sd1 <<< (Q30_UP - 1);
   localparam longint GAIN_Q30     = 64'sd652032874;
   localparam int     CORDIC_STEPS = 30;

   localparam logic signed [15:0] MAX_CODE = 16'sh7FFF;
   localparam logic signed [15:0] MIN_CODE = 16'sh8000;
   localparam logic signed [15:0] ZERO     = 16'sh0000;

   // Matrices that can be written down without any arithmetic.
   localparam rsp_type IDENTITY     = '{MAX_CODE, ZERO, ZERO, ZERO, MAX_CODE, ZERO,
                                        ZERO, ZERO, MAX_CODE};
   localparam rsp_type NEG_IDENTITY = '{MIN_CODE, ZERO, ZERO, ZERO, MIN_CODE, ZERO,
                                        ZERO, ZERO, MIN_CODE};
   localparam rsp_type ALL_MAX      = '{MAX_CODE, MAX_CODE, MAX_CODE, MAX_CODE, MAX_CODE,
                                        MAX_CODE, MAX_CODE, MAX_CODE, MAX_CODE};

   localparam int RANDOM_ITEMS = 1000;
   localparam int QUIET_TAIL   = 150;   // last random items run with no idling
   localparam int HOLD_AT      = 400;   // items accepted before the long output hold
   localparam int LONG_HOLD    = 300;   // cycles of the long output hold
   localparam int DRAIN_CYCLES = 45;    // cycles run on after the last matrix arrives
   localparam int QUIET_LIMIT  = 5000;  // cycles with no transfer before giving up
   localparam int PRINT_LIMIT  = 30;

   // atan(2^-i) in units of 2^-32 turn.
   localparam longint ARCTAN_TURNS [CORDIC_STEPS] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
   };

   typedef struct {
      req_type stim;
      bit      known;   // expected matrix typed in rather than predicted
      rsp_type want;
   } stimulus_row;

   // All inputs of the block hold known values from time zero.
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   stimulus_row directed_rows [$];
   rsp_type     pending_matrices [$];   // predicted matrices, oldest first

   int items_sent       = 0;
   int matrices_checked = 0;
   int mismatches       = 0;
   int stall_odds       = 0;   // one chance in this many of a stall burst; 0 is none
   int stall_left       = 0;
   bit long_hold_done   = 1'b0;

   string entry_names [9] = '{"m00", "m01", "m02", "m10", "m11", "m12",
                              "m20", "m21", "m22"};
   rsp_type                want_matrix;
   logic signed [FIELD_W-1:0] got_entry;
   logic signed [FIELD_W-1:0] want_entry;

   axis_angle_rotation_matrix u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Product of two Q30 values, rounded half up back to Q30.
   function automatic longint q30_product(longint a, longint b);
      return (a * b + HALF_Q30) >>> 30;
   endfunction

   // Q30 value rounded half up to Q1.15 and clamped to the code range.
   function automatic logic signed [FIELD_W-1:0] q30_to_code(longint v);
      longint r;
      r = (v + HALF_LSB) >>> Q30_UP;
      if (r > longint'(MAX_CODE)) r = longint'(MAX_CODE);
      if (r < longint'(MIN_CODE)) r = longint'(MIN_CODE);
      return FIELD_W'(r);
   endfunction

   // Rotation-mode CORDIC on a 32-bit turn fraction. Angles in the left half
   // plane are turned by half a turn first and the result negated, so the
   // iteration only ever sees angles within a quarter turn of zero.
   function automatic void cordic_cos_sin(input logic [15:0] angle,
                                          output longint cos_q30,
                                          output longint sin_q30);
      logic [31:0] phase;
      logic        flip;
      longint      x, y, z, dx, dy;
      phase = {angle, 16'h0000};
      flip = phase[31] ^ phase[30];
      if (flip) phase = phase + 32'h8000_0000;
      z = longint'($signed(phase));
      x = GAIN_Q30;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         // Arithmetic shifts of signed values round toward minus infinity.
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ARCTAN_TURNS[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ARCTAN_TURNS[i];
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      cos_q30 = x;
      sin_q30 = y;
   endfunction

   // R = c*I + (1-c)*a*a^T + s*[a]x, every product rounded to Q30 and the
   // sums kept exact until the final rounding to the output code.
   function automatic rsp_type rodrigues_matrix(req_type item);
      longint ax, ay, az, c, s, one_minus_c;
      longint xxc, yyc, zzc, xyc, xzc, yzc, xs, ys, zs;
      rsp_type m;
      ax = longint'(item.axis_x) <<< Q30_UP;
      ay = longint'(item.axis_y) <<< Q30_UP;
      az = longint'(item.axis_z) <<< Q30_UP;
      cordic_cos_sin(item.angle, c, s);
      one_minus_c = ONE_Q30 - c;
      xxc = q30_product(q30_product(ax, ax), one_minus_c);
      yyc = q30_product(q30_product(ay, ay), one_minus_c);
      zzc = q30_product(q30_product(az, az), one_minus_c);
      xyc = q30_product(q30_product(ax, ay), one_minus_c);
      xzc = q30_product(q30_product(ax, az), one_minus_c);
      yzc = q30_product(q30_product(ay, az), one_minus_c);
      xs  = q30_product(ax, s);
      ys  = q30_product(ay, s);
      zs  = q30_product(az, s);
      m.m00 = q30_to_code(xxc + c);
      m.m01 = q30_to_code(xyc - zs);
      m.m02 = q30_to_code(xzc + ys);
      m.m10 = q30_to_code(xyc + zs);
      m.m11 = q30_to_code(yyc + c);
      m.m12 = q30_to_code(yzc - xs);
      m.m20 = q30_to_code(xzc - ys);
      m.m21 = q30_to_code(yzc + xs);
      m.m22 = q30_to_code(zzc + c);
      return m;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   function automatic void add_case(int x, int y, int z, int angle,
                                    bit known = 1'b0, rsp_type want = '0);
      stimulus_row row;
      row.stim.axis_x = 16'(x);
      row.stim.axis_y = 16'(y);
      row.stim.axis_z = 16'(z);
      row.stim.angle  = 16'(angle);
      row.known = known;
      row.want  = want;
      directed_rows.push_back(row);
   endfunction

   // Most random items carry a unit axis in a random direction, which is what
   // the block is meant for. The rest take raw 16-bit patterns so that every
   // bit of every field toggles and non-unit axes drive entries into
   // saturation. Some angles land right next to a quadrant boundary; at the
   // quarter and three-quarter turn ones the half-turn fold of the CORDIC switches.
   function automatic req_type random_item();
      req_type item;
      real     ux, uy, uz, len;
      int      pick;
      pick = $urandom_range(0, 9);
      item = req_type'({$urandom(), $urandom()});
      if (pick < 6) begin
         do begin
            ux = real'($urandom_range(0, 20000)) - 10000.0;
            uy = real'($urandom_range(0, 20000)) - 10000.0;
            uz = real'($urandom_range(0, 20000)) - 10000.0;
            len = $sqrt(ux * ux + uy * uy + uz * uz);
         end while (len < 100.0);
         item.axis_x = 16'(int'(ux * 32767.0 / len));
         item.axis_y = 16'(int'(uy * 32767.0 / len));
         item.axis_z = 16'(int'(uz * 32767.0 / len));
      end
      if (pick == 9)
         item.angle = 16'($urandom_range(0, 3) << 14) + 16'($urandom_range(0, 4)) - 16'd2;
      return item;
   endfunction

   // Offers one item and returns at the edge where the block takes it. Before
   // the item the input may go idle for a burst; the valid line is assigned
   // at most once per edge, so back-to-back items keep it high throughout.
   task automatic offer_item(input req_type item, input rsp_type want, input int gap_odds);
      int gap;
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      pending_matrices.push_back(want);
      items_sent <= items_sent + 1;
   endtask

   initial begin
      rsp_type want;
      req_type item;
      int      odds;

      // Identities: no rotation leaves the axis irrelevant, and c rounds up
      // to +1.0, which saturates on the diagonal.
      add_case(0, 0, 0, 16'h0000, 1'b1, IDENTITY);
      add_case(32767, 0, 0, 16'h0000, 1'b1, IDENTITY);
      add_case(0, 0, 32767, 16'h0000, 1'b1, IDENTITY);
      // Half turn about a zero axis: only c = -1.0 survives.
      add_case(0, 0, 0, 16'h8000, 1'b1, NEG_IDENTITY);
      // Axis of all -1.0 at a half turn: every entry is +1 or +2, so all
      // nine saturate high.
      add_case(-32768, -32768, -32768, 16'h8000, 1'b1, ALL_MAX);
      // Quarter and eighth turns, and angles next to them, mostly about the principal axes.
      add_case(0, 0, 32767, 16'h4000);
      add_case(32767, 0, 0, 16'hC000);
      add_case(0, 32767, 0, 16'h2000);
      add_case(0, -32768, 0, 16'h6000);
      add_case(0, 0, -32768, 16'h3FFF);
      add_case(0, 0, -32768, 16'hBFFF);
      add_case(23170, 0, 23170, 16'h0001);
      // Unit diagonal axes at a third of a turn either way.
      add_case(18919, 18919, 18919, 16'h5555);
      add_case(-18919, 18919, -18919, 16'hAAAA);
      // Axes well off unit length, pushing entries past both rails.
      add_case(32767, 32767, 32767, 16'h8000);
      add_case(-32768, 32767, 0, 16'h8000);
      add_case(-32768, -32768, -32768, 16'hFFFF);
      add_case(32767, -32768, 32767, 16'h7FFF);
      add_case(32767, 32767, 32767, 16'h4000);
      add_case(-32768, -32768, -32768, 16'h0000);
      add_case(-1, -1, -1, 16'hC000);
      add_case(21845, -21846, 21845, 16'h4001);

      stall_odds <= 6;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         want = directed_rows[i].known ? directed_rows[i].want
                                       : rodrigues_matrix(directed_rows[i].stim);
         offer_item(directed_rows[i].stim, want, 6);
      end

      // Random part in blocks of 100 items: heavy idling, light idling and
      // none at all in turn, and a quiet stretch to close.
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k >= RANDOM_ITEMS - QUIET_TAIL) odds = 0;
         else if ((k / 100) % 3 == 0) odds = 4;
         else if ((k / 100) % 3 == 1) odds = 12;
         else odds = 0;
         stall_odds <= odds;
         item = random_item();
         offer_item(item, rodrigues_matrix(item), odds);
      end
      req_valid <= 1'b0;

      while (pending_matrices.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d rotation matrices: %0d directed rows and %0d random items,",
               matrices_checked, directed_rows.size(), RANDOM_ITEMS);
      $display("with random output stalls, one %0d-cycle hold and %0d mismatches.",
               LONG_HOLD, mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result side: stall pattern and checking
   // ---------------------------------------------------------------------

   // Random stall bursts, plus one long hold once enough items have gone in.
   // The sender keeps offering during the hold, so the pipeline fills and the
   // block has to push back on its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!long_hold_done && items_sent >= HOLD_AT) begin
         rsp_stall      <= 1'b1;
         stall_left     <= LONG_HOLD - 1;
         long_hold_done <= 1'b1;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 18);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic report_mismatch(input string what);
      if (mismatches < PRINT_LIMIT)
         $display("ERROR at %0t: %s", $time, what);
      mismatches++;
   endtask

   // Each matrix taken from the block is compared entry by entry with the
   // oldest prediction still waiting.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_matrices.size() == 0) begin
            report_mismatch("matrix delivered with no item outstanding");
         end else begin
            want_matrix = pending_matrices.pop_front();
            for (int k = 0; k < 9; k++) begin
               got_entry  = rsp_data[(8 - k) * FIELD_W +: FIELD_W];
               want_entry = want_matrix[(8 - k) * FIELD_W +: FIELD_W];
               if (got_entry !== want_entry)
                  report_mismatch($sformatf("matrix %0d entry %s is %0d, expected %0d",
                                            matrices_checked, entry_names[k],
                                            got_entry, want_entry));
            end
            matrices_checked++;
         end
      end
   end

   // Ends the run if nothing moves on either channel for too long, which is
   // also how a lost matrix shows up.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Timed out with %0d matrices still expected.", pending_matrices.size());
      $display("FAIL");
      $finish;
   end

endmodule
